FILE: hdl/atrp_pkg.sv
// atrp_pkg: shared constants and tables for the accelerometer tilt core
// depends on nothing
`timescale 1ns / 1ps

package atrp_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int ITERATIONS_DEF    = 16;

    localparam int WEIGHT_BITS  = 8;
    localparam int WEIGHT_W     = 9;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd51;
    localparam int RANGE_MG     = 2000;
    localparam int GUARD_BITS   = 16;
    localparam int ANGLE_SHIFT  = 16;
    localparam int TABLE_LEN    = 24;
    localparam int ACC_W        = 48;
    localparam int ROLL_W       = 16;
    localparam int PITCH_W      = 15;
    localparam int MG_W         = 12;
    localparam int HALF_TURN    = 18000;
    localparam int QUARTER_TURN = 9000;

    // arctangent of 2^-i in 1/65536 of a hundredth of a degree
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'd294912000;
                5'd1:  v = 32'd174096719;
                5'd2:  v = 32'd91987925;
                5'd3:  v = 32'd46694507;
                5'd4:  v = 32'd23437865;
                5'd5:  v = 32'd11730358;
                5'd6:  v = 32'd5866610;
                5'd7:  v = 32'd2933484;
                5'd8:  v = 32'd1466764;
                5'd9:  v = 32'd733385;
                5'd10: v = 32'd366693;
                5'd11: v = 32'd183346;
                5'd12: v = 32'd91673;
                5'd13: v = 32'd45837;
                5'd14: v = 32'd22918;
                5'd15: v = 32'd11459;
                5'd16: v = 32'd5730;
                5'd17: v = 32'd2865;
                5'd18: v = 32'd1432;
                5'd19: v = 32'd716;
                5'd20: v = 32'd358;
                5'd21: v = 32'd179;
                5'd22: v = 32'd90;
                5'd23: v = 32'd45;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: hdl/accel_tilt_roll_pitch_core.sv
// accel_tilt_roll_pitch_core: accelerometer tilt top level
// depends on atrp_pkg, atrp_front, atrp_back
//
// usage: one 3-axis sample beat in on s_axis, one result beat out on m_axis.
// s_axis_tdata: accel_x, accel_y, accel_z (12 bits each, from bit 0 up).
// m_axis_tdata: roll_centideg (16), pitch_centideg (15), x/y/z_milli_g
// (12 each), from bit 0 up, zero-filled to 72 bits.
// the user must write the filter weight by i_cfg_we / i_cfg_wdata only
// while idle; the core leaves this check to the user. a sample passes the
// filter stage register and the idle hand-over, then a 21-step square root,
// a load state, a 16-step roll pass and a pitch pass (set-up, 16 steps, finish).
// the back part takes a new sample only after the last result is taken.
// the filter stage register holds one further sample while the back part
// works or a result waits; beyond that the input stops.
// reset clears the filter, its primed flag and sets the weight to 51.
// when the receiver stalls the result is held and the input stops.
`timescale 1ns / 1ps

module accel_tilt_roll_pitch_core #(
    parameter int SAMPLE_BITS       = atrp_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS     = atrp_pkg::FRACTION_BITS_DEF,
    parameter int CORDIC_ITERATIONS = atrp_pkg::ITERATIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [atrp_pkg::WEIGHT_W-1:0] i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // accel_x, accel_y, accel_z from bit 0 up
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // roll_centideg, pitch_centideg, x_milli_g, y_milli_g, z_milli_g from bit 0 up
    output logic [71:0]                   m_axis_tdata
);
    localparam int FW = SAMPLE_BITS + FRACTION_BITS;
    localparam int DW = atrp_pkg::ROLL_W + atrp_pkg::PITCH_W + 3 * atrp_pkg::MG_W;

    logic [atrp_pkg::WEIGHT_W-1:0] r_weight;
    logic q_valid, q_ready;
    logic signed [FW-1:0] q_fx, q_fy, q_fz;
    logic [3*atrp_pkg::MG_W-1:0] q_mg;
    logic [DW-1:0] w_data;

    // weight register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_weight <= atrp_pkg::WEIGHT_RESET;
        else if (i_cfg_we) r_weight <= i_cfg_wdata;
    end

    atrp_front #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_weight(r_weight),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_x(s_axis_tdata[0 +: SAMPLE_BITS]),
        .i_y(s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS]),
        .i_z(s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
        .o_valid(q_valid), .i_ready(q_ready),
        .o_fx(q_fx), .o_fy(q_fy), .o_fz(q_fz), .o_mg(q_mg)
    );

    atrp_back #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS),
                .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_fx(q_fx), .i_fy(q_fy), .i_fz(q_fz), .i_mg(q_mg),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_data)
    );

    assign m_axis_tdata = {{(72 - DW){1'b0}}, w_data};

endmodule

FILE: hdl/atrp_front.sv
// atrp_front: input stage, low-pass filter update and milli-g scaling
// depends on atrp_pkg; feeds atrp_back
`timescale 1ns / 1ps

module atrp_front #(
    parameter int SAMPLE_BITS   = atrp_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = atrp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [atrp_pkg::WEIGHT_W-1:0]           i_weight,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [SAMPLE_BITS-1:0]           i_x,
    input  logic signed [SAMPLE_BITS-1:0]           i_y,
    input  logic signed [SAMPLE_BITS-1:0]           i_z,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] o_fx,
    output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] o_fy,
    output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] o_fz,
    output logic [3*atrp_pkg::MG_W-1:0]             o_mg
);
    localparam int FW = SAMPLE_BITS + FRACTION_BITS;
    localparam int PW = FW + atrp_pkg::WEIGHT_W + 2;
    localparam int MW = SAMPLE_BITS + 12;

    logic signed [FW-1:0] r_filt [3];
    logic                 r_primed;
    logic                 r_valid;
    logic signed [FW-1:0] r_out  [3];
    logic [3*atrp_pkg::MG_W-1:0] r_mg;

    logic signed [SAMPLE_BITS-1:0] w_s [3];
    logic signed [FW-1:0]          n_filt [3];
    logic [3*atrp_pkg::MG_W-1:0]   n_mg;
    logic signed [atrp_pkg::WEIGHT_W:0] w_w;

    assign w_s[0] = i_x;
    assign w_s[1] = i_y;
    assign w_s[2] = i_z;
    assign w_w = (i_weight > atrp_pkg::WEIGHT_MAX) ? {1'b0, atrp_pkg::WEIGHT_MAX}
                                                   : {1'b0, i_weight};
    assign o_ready = !r_valid || i_ready;

    // filter update and milli-g scaling per axis
    always_comb begin
        logic signed [FW-1:0]   tgt;
        logic signed [FW:0]     diff;
        logic signed [PW-1:0]   prod;
        logic signed [MW-1:0]   mg;
        for (int a = 0; a < 3; a++) begin
            tgt  = FW'(w_s[a]) <<< FRACTION_BITS;
            diff = (FW+1)'(tgt) - (FW+1)'(r_filt[a]);
            prod = PW'(diff) * PW'(w_w);
            n_filt[a] = r_primed ? FW'(r_filt[a] + FW'(prod >>> atrp_pkg::WEIGHT_BITS)) : tgt;
            mg   = MW'(w_s[a]) * MW'(atrp_pkg::RANGE_MG);
            n_mg[a*atrp_pkg::MG_W +: atrp_pkg::MG_W] =
                atrp_pkg::MG_W'(mg >>> (SAMPLE_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_valid  <= 1'b0;
            for (int a = 0; a < 3; a++) r_filt[a] <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_primed <= 1'b1;
                r_valid  <= 1'b1;
                for (int a = 0; a < 3; a++) r_filt[a] <= n_filt[a];
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output register of filtered beat
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            for (int a = 0; a < 3; a++) r_out[a] <= n_filt[a];
            r_mg <= n_mg;
        end
    end

    assign o_valid = r_valid;
    assign o_fx = r_out[0];
    assign o_fy = r_out[1];
    assign o_fz = r_out[2];
    assign o_mg = r_mg;

endmodule

FILE: hdl/atrp_back.sv
// atrp_back: magnitude square root and two CORDIC vectoring passes sharing registers
// depends on atrp_pkg; takes filtered beats from atrp_front
`timescale 1ns / 1ps

module atrp_back #(
    parameter int SAMPLE_BITS       = atrp_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS     = atrp_pkg::FRACTION_BITS_DEF,
    parameter int CORDIC_ITERATIONS = atrp_pkg::ITERATIONS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] i_fx,
    input  logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] i_fy,
    input  logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] i_fz,
    input  logic [3*atrp_pkg::MG_W-1:0]                 i_mg,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [atrp_pkg::ROLL_W+atrp_pkg::PITCH_W+3*atrp_pkg::MG_W-1:0] o_data
);
    localparam int FW   = SAMPLE_BITS + FRACTION_BITS;
    localparam int SQW  = 2 * FW + 2;
    localparam int RW   = FW + 1;
    localparam int CW   = FW + 3 + atrp_pkg::GUARD_BITS;
    localparam int NIT  = (CORDIC_ITERATIONS < atrp_pkg::TABLE_LEN) ?
                          CORDIC_ITERATIONS : atrp_pkg::TABLE_LEN;
    localparam int SQIT = SQW / 2;
    localparam int CNTW = $clog2(SQIT + 1) + 1;
    localparam int AW   = atrp_pkg::ACC_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SQRT  = 6'b000010,
        S_ROLL  = 6'b000100,
        S_PITCH = 6'b001000,
        S_LOAD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CNTW-1:0] r_cnt;
    logic signed [FW-1:0] r_px;
    logic [3*atrp_pkg::MG_W-1:0] r_mg;
    logic [SQW-1:0] r_rem;
    logic [SQW-1:0] r_root;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [AW-1:0] r_acc;
    logic signed [atrp_pkg::ROLL_W-1:0] r_roll;
    logic signed [atrp_pkg::PITCH_W-1:0] r_pitch;
    logic r_zero;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = {r_mg, r_pitch, r_roll};

    // one restoring square root step: one result bit per pair
    logic [SQW-1:0] w_bit, w_trial;
    assign w_bit   = SQW'(1) << (2 * (SQIT - 1 - int'(r_cnt)));
    assign w_trial = r_root + w_bit;

    // cordic step of the roll pass
    logic signed [CW-1:0] w_xs, w_ys;
    logic [4:0] w_i;
    logic signed [AW-1:0] w_tab;
    assign w_i   = 5'(r_cnt);
    assign w_xs  = r_cx >>> w_i;
    assign w_ys  = r_cy >>> w_i;
    assign w_tab = AW'(atrp_pkg::atan_entry(w_i));

    // finished angle, truncated toward zero
    logic signed [AW-1:0] w_q;
    assign w_q = (r_acc < 0) ? -((-r_acc) >>> atrp_pkg::ANGLE_SHIFT)
                             : (r_acc >>> atrp_pkg::ANGLE_SHIFT);

    // vector set-up for a vectoring pass
    function automatic void setup(input logic signed [RW:0] x, input logic signed [RW:0] y,
                                  output logic signed [CW-1:0] cx,
                                  output logic signed [CW-1:0] cy,
                                  output logic signed [AW-1:0] acc,
                                  output logic zero);
        begin
            zero = (x == 0) && (y == 0);
            if (x < 0) begin
                acc = (y >= 0) ? AW'(atrp_pkg::HALF_TURN) <<< atrp_pkg::ANGLE_SHIFT
                               : -(AW'(atrp_pkg::HALF_TURN) <<< atrp_pkg::ANGLE_SHIFT);
                cx = CW'(-x) <<< atrp_pkg::GUARD_BITS;
                cy = CW'(-y) <<< atrp_pkg::GUARD_BITS;
            end else begin
                acc = '0;
                cx = CW'(x) <<< atrp_pkg::GUARD_BITS;
                cy = CW'(y) <<< atrp_pkg::GUARD_BITS;
            end
        end
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_SQRT;
            S_SQRT:  if (int'(r_cnt) == SQIT - 1) n_state = S_LOAD;
            S_LOAD:  n_state = S_ROLL;
            S_ROLL:  if (int'(r_cnt) == NIT - 1) n_state = S_PITCH;
            S_PITCH: if (int'(r_cnt) == NIT + 1) n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_cnt <= '0;
            else                    r_cnt <= r_cnt + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] sx, sy;
        logic signed [AW-1:0] sa;
        logic sz;
        logic signed [AW-1:0] lim;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_px   <= i_fx;
                    r_mg   <= i_mg;
                    r_rem  <= SQW'((2*FW)'(i_fy) * (2*FW)'(i_fy)) +
                              SQW'((2*FW)'(i_fz) * (2*FW)'(i_fz));
                    r_root <= '0;
                    setup((RW+1)'(i_fz), (RW+1)'(i_fy), sx, sy, sa, sz);
                    r_cx <= sx; r_cy <= sy; r_acc <= sa; r_zero <= sz;
                end
            end
            S_SQRT: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            S_LOAD: ;
            S_ROLL, S_PITCH: begin
                if (r_state == S_PITCH && r_cnt == '0) begin
                    // finish roll and start pitch
                    lim = AW'(atrp_pkg::HALF_TURN);
                    r_roll <= r_zero ? '0 : atrp_pkg::ROLL_W'((w_q > lim) ? lim :
                              (w_q < -lim) ? -lim : w_q);
                    setup((RW+1)'(r_root), -((RW+1)'(r_px)), sx, sy, sa, sz);
                    r_cx <= sx; r_cy <= sy; r_acc <= sa; r_zero <= sz;
                end else if (r_state == S_PITCH) begin
                    if (int'(r_cnt) <= NIT) begin
                        r_cx <= (r_cy >= 0) ? r_cx + ($signed(r_cy) >>> (w_i - 5'd1))
                                            : r_cx - ($signed(r_cy) >>> (w_i - 5'd1));
                        r_cy <= (r_cy >= 0) ? r_cy - ($signed(r_cx) >>> (w_i - 5'd1))
                                            : r_cy + ($signed(r_cx) >>> (w_i - 5'd1));
                        r_acc <= (r_cy >= 0) ? r_acc + AW'(atrp_pkg::atan_entry(w_i - 5'd1))
                                             : r_acc - AW'(atrp_pkg::atan_entry(w_i - 5'd1));
                    end
                end else begin
                    r_cx  <= (r_cy >= 0) ? r_cx + w_ys : r_cx - w_ys;
                    r_cy  <= (r_cy >= 0) ? r_cy - w_xs : r_cy + w_xs;
                    r_acc <= (r_cy >= 0) ? r_acc + w_tab : r_acc - w_tab;
                end
                // pitch after its last iteration has landed
                if (r_state == S_PITCH && int'(r_cnt) == NIT + 1) begin
                    lim = AW'(atrp_pkg::QUARTER_TURN);
                    r_pitch <= r_zero ? '0 : atrp_pkg::PITCH_W'((w_q > lim) ? lim :
                               (w_q < -lim) ? -lim : w_q);
                end
            end
            default: ;
        endcase
    end

    // result shows only with a finished pass behind it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_PITCH)
        else $error("result without pitch pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("accepting while holding a result");

endmodule

FILE: verif/tb_accel_tilt_roll_pitch_core.sv
// tb_accel_tilt_roll_pitch_core: self-checking bench for the accelerometer tilt core
// drives sample beats, predicts roll, pitch and milli-g, and checks every result beat
// depends on atrp_pkg and accel_tilt_roll_pitch_core
`timescale 1ns / 1ps

module tb_accel_tilt_roll_pitch_core;

    localparam int SBITS  = atrp_pkg::SAMPLE_BITS_DEF;
    localparam int FBITS  = atrp_pkg::FRACTION_BITS_DEF;
    localparam int ITERS  = atrp_pkg::ITERATIONS_DEF;
    localparam int WBITS  = atrp_pkg::WEIGHT_W;
    localparam int RBITS  = atrp_pkg::ROLL_W;
    localparam int PBITS  = atrp_pkg::PITCH_W;
    localparam int MBITS  = atrp_pkg::MG_W;
    localparam int TLEN   = atrp_pkg::TABLE_LEN;
    localparam int DRAIN  = 90;

    typedef struct packed {
        logic signed [MBITS-1:0] z_mg;
        logic signed [MBITS-1:0] y_mg;
        logic signed [MBITS-1:0] x_mg;
        logic signed [PBITS-1:0] pitch;
        logic signed [RBITS-1:0] roll;
    } t_tilt_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [WBITS-1:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // accel_x, accel_y, accel_z from bit 0 up, zero-filled to 40 bits
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // roll, pitch, x/y/z milli-g from bit 0 up, zero-filled to 72 bits
    logic [71:0] m_axis_tdata;

    // predictor state
    longint      axis_filt[3];
    bit          filt_primed;
    int unsigned filt_weight;
    longint      atan_lut[TLEN] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45};

    t_tilt_result tilt_due[$];
    int  err_count = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    bit  idle_on = 1'b1;
    int  hold_req = 0;
    int  rx_stall = 0;

    accel_tilt_roll_pitch_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        if (!idle_on) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // integer square root by bit pairs
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // vectoring cordic angle of (vx, vy) in centidegrees
    function automatic longint vector_angle(longint vx, longint vy, longint lim);
        longint acc;
        longint xs;
        longint ys;
        longint q;
        acc = 0;
        if (vx == 0 && vy == 0) return 0;
        // left half plane: flip and start from a half turn
        if (vx < 0) begin
            acc = (vy >= 0 ? 64'sd18000 : -64'sd18000) * 64'sd65536;
            vx = -vx;
            vy = -vy;
        end
        vx = vx <<< atrp_pkg::GUARD_BITS;
        vy = vy <<< atrp_pkg::GUARD_BITS;
        for (int i = 0; i < ITERS && i < TLEN; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx += ys;
                vy -= xs;
                acc += atan_lut[i];
            end else begin
                vx -= ys;
                vy += xs;
                acc -= atan_lut[i];
            end
        end
        q = acc / 64'sd65536;
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    // filter update and angle prediction for one accepted sample
    function automatic t_tilt_result predict_tilt(logic signed [SBITS-1:0] ax,
                                                  logic signed [SBITS-1:0] ay,
                                                  logic signed [SBITS-1:0] az);
        longint       smp[3];
        longint       w;
        longint       mag;
        t_tilt_result r;
        smp[0] = ax;
        smp[1] = ay;
        smp[2] = az;
        w = (filt_weight > 256) ? 256 : filt_weight;
        for (int i = 0; i < 3; i++) begin
            if (filt_primed)
                axis_filt[i] += (w * ((smp[i] <<< FBITS) - axis_filt[i])) >>>
                                atrp_pkg::WEIGHT_BITS;
            else
                axis_filt[i] = smp[i] <<< FBITS;
        end
        filt_primed = 1'b1;
        mag = longint'(int_sqrt(axis_filt[1] * axis_filt[1] + axis_filt[2] * axis_filt[2]));
        r.roll  = RBITS'(vector_angle(axis_filt[2], axis_filt[1], atrp_pkg::HALF_TURN));
        r.pitch = PBITS'(vector_angle(mag, -axis_filt[0], atrp_pkg::QUARTER_TURN));
        r.x_mg  = MBITS'((smp[0] * atrp_pkg::RANGE_MG) >>> (SBITS - 1));
        r.y_mg  = MBITS'((smp[1] * atrp_pkg::RANGE_MG) >>> (SBITS - 1));
        r.z_mg  = MBITS'((smp[2] * atrp_pkg::RANGE_MG) >>> (SBITS - 1));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // send one sample beat; valid stays high when no gap follows
    task automatic send_sample(logic signed [SBITS-1:0] ax, logic signed [SBITS-1:0] ay,
                               logic signed [SBITS-1:0] az);
        int gap;
        s_axis_tdata  <= {4'd0, az, ay, ax};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        tilt_due.push_back(predict_tilt(ax, ay, az));
        beats_in++;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        send_sample(SBITS'($urandom), SBITS'($urandom), SBITS'($urandom));
    endtask

    // wait for every result, then let the back part settle
    task automatic drain();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tilt_due.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        if (tilt_due.size() != 0) begin
            err_count++;
            $display("%0t %0d results never arrived", $realtime, tilt_due.size());
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_weight(logic [WBITS-1:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        filt_weight = 32'(w);
    endtask

    // first sample loads the filter, then field extremes and quadrants
    task automatic test_directed();
        send_sample(12'sd300, -12'sd700, 12'sd1000);
        set_weight_idle(9'd256);
        send_sample(12'sh800, 12'sh800, 12'sh800);
        send_sample(12'sd2047, 12'sd2047, 12'sd2047);
        send_sample(12'sd0, 12'sd0, 12'sd0);
        send_sample(12'sd0, 12'sd0, -12'sd1024);
        send_sample(12'sd0, 12'sd5, -12'sd1024);
        send_sample(12'sd0, -12'sd5, -12'sd1024);
        send_sample(12'sd0, 12'sd1024, 12'sd0);
        send_sample(12'sd0, -12'sd1024, 12'sd0);
        send_sample(-12'sd1024, 12'sd0, 12'sd0);
        send_sample(12'sd1024, 12'sd0, 12'sd0);
        send_sample(12'sd1, -12'sd1, -12'sd1);
        send_sample(-12'sd1, 12'sd1, 12'sd1);
        send_sample(12'sd2047, 12'sh800, 12'sd1);
    endtask

    task automatic set_weight_idle(logic [WBITS-1:0] w);
        drain();
        set_weight(w);
    endtask

    // random samples under a sweep of filter weights
    task automatic test_weights();
        logic [WBITS-1:0] wlist[8] = '{9'd51, 9'd0, 9'd1, 9'd256, 9'd511,
                                       9'd257, 9'd128, 9'd255};
        foreach (wlist[k]) begin
            set_weight_idle(wlist[k]);
            idle_on = (k != 3);
            for (int j = 0; j < 40; j++) begin
                // random tilts around a gravity vector along z, with some fully random noise beats
                if ($urandom_range(0, 3) == 0) send_random();
                else send_sample(SBITS'(int'($urandom_range(0, 1400)) - 700),
                                 SBITS'(int'($urandom_range(0, 1400)) - 700),
                                 SBITS'(($urandom_range(0, 1) != 0 ? 1 : -1) *
                                        int'($urandom_range(600, 1100))));
            end
        end
        idle_on = 1'b1;
        set_weight_idle(WBITS'($urandom_range(0, 511)));
        repeat (60) send_random();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        drain();
        idle_on  = 1'b0;
        hold_req = 500;
        repeat (12) send_random();
        idle_on  = 1'b1;
        repeat (20) send_random();
    endtask

    // receiver ready with random stalls and a requested long hold
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            rx_stall = hold_req;
            hold_req = 0;
        end
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall = gap_len();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_tilt_result got;
        t_tilt_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[66:0];
            beats_out++;
            if (tilt_due.size() == 0) begin
                err_count++;
                $display("%0t result beat with nothing outstanding", $realtime);
            end else begin
                want = tilt_due.pop_front();
                if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
                if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
                if (got.x_mg !== want.x_mg) report_mismatch("x_milli_g", got.x_mg, want.x_mg);
                if (got.y_mg !== want.y_mg) report_mismatch("y_milli_g", got.y_mg, want.y_mg);
                if (got.z_mg !== want.z_mg) report_mismatch("z_milli_g", got.z_mg, want.z_mg);
            end
        end
    end

    // watchdog
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        axis_filt   = '{0, 0, 0};
        filt_primed = 1'b0;
        filt_weight = 32'(atrp_pkg::WEIGHT_RESET);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_weights();
        test_backpressure();
        drain();
        $display("covered %0d sample beats in, %0d result beats out", beats_in, beats_out);
        $display("weights 0..511 incl. saturation, all quadrants, long receiver hold");
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
